// ===== hdl/hcfd_pkg.sv =====
`timescale 1ns / 1ps

package hcfd_pkg;

  localparam int unsigned FrameBytes   = 16;
  localparam int unsigned PosW         = $clog2(FrameBytes);
  localparam int unsigned StoredBytes  = 13;
  localparam int unsigned LastSumPos   = 14;

  localparam logic [PosW-1:0] PosHead = PosW'(0);
  localparam logic [PosW-1:0] PosTail = PosW'(FrameBytes - 1);

  // frame type codes (byte 1)
  localparam logic [7:0] TypeTake     = 8'h02;
  localparam logic [7:0] TypeReturn   = 8'h03;
  localparam logic [7:0] TypeVelocity = 8'h10;
  localparam logic [7:0] TypePitch    = 8'h11;
  localparam logic [7:0] TypeMagazine = 8'h12;
  localparam logic [7:0] TypeFire     = 8'h13;

  // required data byte (byte 2)
  localparam logic [7:0] DataControl = 8'hF0;
  localparam logic [7:0] DataFire    = 8'hF1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SUM_BAD  = 3'd1,
    ST_XOR_BAD  = 3'd2,
    ST_DATA_BAD = 3'd3,
    ST_NOT_AUTO = 3'd4,
    ST_UNKNOWN  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_TAKE     = 3'd1,
    CMD_RETURN   = 3'd2,
    CMD_VELOCITY = 3'd3,
    CMD_PITCH    = 3'd4,
    CMD_MAGAZINE = 3'd5,
    CMD_FIRE     = 3'd6
  } command_e;

  typedef enum logic [1:0] {
    MODE_MANUAL      = 2'd0,
    MODE_MATCH       = 2'd1,
    MODE_CANNON_TEST = 2'd2,
    MODE_MATCH_AUTO  = 2'd3
  } mode_e;

  // collected frame state handed to the decoder
  typedef struct packed {
    logic                          tail;   // current beat is byte 15
    logic [7:0]                    head;
    logic [7:0]                    sum;
    logic [7:0]                    xsum;
    logic [StoredBytes-1:0][7:0]   bytes;  // frame bytes 1..13
  } frame_t;

  typedef struct packed {
    status_e     status;
    command_e    command;
    mode_e       mode;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
  } result_t;

endpackage

// ===== hdl/hcfd_collect.sv =====
`timescale 1ns / 1ps

module hcfd_collect import hcfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  output frame_t     frame_o
);

  logic [PosW-1:0]                 pos_q, pos_d, pos;
  logic [7:0]                      sum_q, sum_d;
  logic [7:0]                      xor_q, xor_d;
  logic [7:0]                      head_q;
  logic [StoredBytes-1:0][7:0]     bytes_q;

  // frame start forces byte 0 and drops any partial frame
  assign pos   = frame_start_i ? PosHead : pos_q;
  assign pos_d = pos + PosW'(1);

  always_comb begin
    sum_d = sum_q;
    xor_d = xor_q;
    if (pos == PosHead) begin
      sum_d = 8'h00;
      xor_d = 8'h00;
    end else if (pos <= PosW'(LastSumPos)) begin
      sum_d = sum_q + rx_byte_i;
      xor_d = xor_q ^ rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHead;
      sum_q <= 8'h00;
      xor_q <= 8'h00;
    end else if (beat_i) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      xor_q <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i) begin
      if (pos == PosHead) begin
        head_q <= rx_byte_i;
      end
      for (int i = 0; i < StoredBytes; i++) begin
        if (pos == PosW'(i + 1)) begin
          bytes_q[i] <= rx_byte_i;
        end
      end
    end
  end

  assign frame_o.tail  = (pos == PosTail);
  assign frame_o.head  = head_q;
  assign frame_o.sum   = sum_q;
  assign frame_o.xsum  = xor_q;
  assign frame_o.bytes = bytes_q;

endmodule

// ===== hdl/hcfd_decode.sv =====
`timescale 1ns / 1ps

module hcfd_decode import hcfd_pkg::*; (
  input  frame_t     frame_i,
  input  logic [7:0] rx_byte_i,
  input  mode_e      mode_i,
  output result_t    result_o
);

  logic [7:0] ftype;
  logic [7:0] fdata;

  assign ftype = frame_i.bytes[0];
  assign fdata = frame_i.bytes[1];

  always_comb begin
    result_o.status  = ST_OK;
    result_o.command = CMD_NONE;
    result_o.mode    = mode_i;
    // words are always the raw frame bytes, little endian
    result_o.word_one   = {frame_i.bytes[4],  frame_i.bytes[3],
                           frame_i.bytes[2],  frame_i.bytes[1]};
    result_o.word_two   = {frame_i.bytes[8],  frame_i.bytes[7],
                           frame_i.bytes[6],  frame_i.bytes[5]};
    result_o.word_three = {frame_i.bytes[12], frame_i.bytes[11],
                           frame_i.bytes[10], frame_i.bytes[9]};

    if (frame_i.head != frame_i.sum) begin
      result_o.status = ST_SUM_BAD;
    end else if (rx_byte_i != frame_i.xsum) begin
      result_o.status = ST_XOR_BAD;
    end else begin
      case (ftype) inside
        TypeTake, TypeReturn: begin
          result_o.command = (ftype == TypeTake) ? CMD_TAKE : CMD_RETURN;
          if (fdata != DataControl) begin
            result_o.status = ST_DATA_BAD;
          end else begin
            result_o.mode = (ftype == TypeTake) ? MODE_MATCH_AUTO : MODE_MATCH;
          end
        end
        TypeVelocity, TypePitch, TypeMagazine, TypeFire: begin
          case (ftype)
            TypeVelocity: result_o.command = CMD_VELOCITY;
            TypePitch:    result_o.command = CMD_PITCH;
            TypeMagazine: result_o.command = CMD_MAGAZINE;
            default:      result_o.command = CMD_FIRE;
          endcase
          // mode is tested before the fire data byte
          if (mode_i != MODE_MATCH_AUTO) begin
            result_o.status = ST_NOT_AUTO;
          end else if (ftype == TypeFire && fdata != DataFire) begin
            result_o.status = ST_DATA_BAD;
          end
        end
        default: begin
          result_o.status = ST_UNKNOWN;
        end
      endcase
    end
  end

endmodule

// ===== hdl/host_command_frame_decoder_core.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-------------------------------------
// in       | input     | in_valid_i/in_ready_o | rx_byte_i, frame_start_i
// out      | output    | out_valid_o/out_ready_i | status_o, command_o, mode_now_o,
//          |           |                       | word_one_o, word_two_o, word_three_o
//
// One input beat per cycle while in_ready_o is high; a frame takes 16 beats and yields one result beat,
// registered at the edge that takes byte 15 and offered from the next cycle.
// The per-beat sum, xor and byte store, and the byte-15 decode, are each combinational
// logic between the frame registers and the result register.
// Reset: byte position, sums, result valid and the kept mode (manual) are cleared.
// Stalls: input is taken while the result register is empty or being drained,
// so a waiting result blocks the input only if out_ready_i stays low.

module host_command_frame_decoder_core import hcfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  command_o,
  output logic [1:0]  mode_now_o,
  output logic [31:0] word_one_o,
  output logic [31:0] word_two_o,
  output logic [31:0] word_three_o
);

  frame_t  frame;
  result_t result;
  result_t res_q;
  mode_e   mode_q;
  logic    out_valid_q, out_valid_d;
  logic    in_beat;
  logic    load;

  // take a beat whenever the result register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_beat    = in_valid_i && in_ready_o;
  // load the result register on byte 15 of a frame
  assign load       = in_beat && frame.tail;

  hcfd_collect u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (in_beat),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .frame_o       (frame)
  );

  hcfd_decode u_decode (
    .frame_i   (frame),
    .rx_byte_i (rx_byte_i),
    .mode_i    (mode_q),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= MODE_MANUAL;
    end else begin
      out_valid_q <= out_valid_d;
      // the decoder only moves the mode on a good control frame
      if (load) begin
        mode_q <= result.mode;
      end
    end
  end

  // hold the result payload until a new frame completes
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign command_o    = res_q.command;
  assign mode_now_o   = res_q.mode;
  assign word_one_o   = res_q.word_one;
  assign word_two_o   = res_q.word_two;
  assign word_three_o = res_q.word_three;

`ifndef ASSERT_OFF
  a_mode_only_on_control : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !(result.status == ST_OK &&
               (result.command == CMD_TAKE || result.command == CMD_RETURN)))
    |=> $stable(mode_q))
    else $error("mode changed without a good control frame");

  a_mode_hold_no_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(mode_q))
    else $error("mode changed outside a frame end");

  a_check_fail_no_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.status == ST_SUM_BAD || res_q.status == ST_XOR_BAD ||
                     res_q.status == ST_UNKNOWN))
    |-> (res_q.command == CMD_NONE))
    else $error("command given on a failed check");

  a_result_mode_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (res_q.mode == mode_q))
    else $error("reported mode differs from kept mode");
`endif

endmodule

// ===== bench/tb_host_command_frame_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_host_command_frame_decoder_core;
  import hcfd_pkg::*;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_XOR, FLAW_BOTH} flaw_e;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        frame_start_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [2:0]  command_o;
  logic [1:0]  mode_now_o;
  logic [31:0] word_one_o;
  logic [31:0] word_two_o;
  logic [31:0] word_three_o;

  // Frame tracker: position, running checks, stored bytes and the kept mode
  logic [PosW-1:0] rx_pos;
  logic [7:0]      rx_head;
  logic [7:0]      rx_sum;
  logic [7:0]      rx_xor;
  logic [7:0]      rx_bytes [StoredBytes];
  mode_e           kept_mode;
  result_t         results_due [$];

  int error_count;
  int beats_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int recv_hold_left;

  host_command_frame_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .command_o     (command_o),
    .mode_now_o    (mode_now_o),
    .word_one_o    (word_one_o),
    .word_two_o    (word_two_o),
    .word_three_o  (word_three_o)
  );

  always #5 clk_i = ~clk_i;

  // Advance the tracker by one accepted beat; queue the frame result on byte 15
  function automatic void track_byte(input logic [7:0] b, input logic start);
    logic [PosW-1:0] pos;
    result_t         res;
    if (start) rx_pos = PosHead;
    pos    = rx_pos;
    rx_pos = pos + PosW'(1);
    if (pos == PosHead) begin
      rx_head = b;
      rx_sum  = '0;
      rx_xor  = '0;
    end else if (pos != PosTail) begin
      rx_sum = rx_sum + b;
      rx_xor = rx_xor ^ b;
      if (pos <= PosW'(StoredBytes)) rx_bytes[pos - PosW'(1)] = b;
    end else begin
      res.status  = ST_OK;
      res.command = CMD_NONE;
      // sum before xor before type
      if (rx_head != rx_sum) begin
        res.status = ST_SUM_BAD;
      end else if (b != rx_xor) begin
        res.status = ST_XOR_BAD;
      end else begin
        case (rx_bytes[0])
          TypeTake, TypeReturn: begin
            res.command = (rx_bytes[0] == TypeTake) ? CMD_TAKE : CMD_RETURN;
            if (rx_bytes[1] != DataControl) res.status = ST_DATA_BAD;
            else kept_mode = (rx_bytes[0] == TypeTake) ? MODE_MATCH_AUTO : MODE_MATCH;
          end
          TypeVelocity, TypePitch, TypeMagazine, TypeFire: begin
            case (rx_bytes[0])
              TypeVelocity: res.command = CMD_VELOCITY;
              TypePitch:    res.command = CMD_PITCH;
              TypeMagazine: res.command = CMD_MAGAZINE;
              default:      res.command = CMD_FIRE;
            endcase
            // mode is tested ahead of the fire data byte
            if (kept_mode != MODE_MATCH_AUTO) res.status = ST_NOT_AUTO;
            else if (rx_bytes[0] == TypeFire && rx_bytes[1] != DataFire)
              res.status = ST_DATA_BAD;
          end
          default: res.status = ST_UNKNOWN;
        endcase
      end
      res.mode       = kept_mode;
      res.word_one   = {rx_bytes[4], rx_bytes[3], rx_bytes[2], rx_bytes[1]};
      res.word_two   = {rx_bytes[8], rx_bytes[7], rx_bytes[6], rx_bytes[5]};
      res.word_three = {rx_bytes[12], rx_bytes[11], rx_bytes[10], rx_bytes[9]};
      results_due.push_back(res);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (results_due.size() == 0) begin
      $error("result beat with no frame outstanding");
      error_count++;
      return;
    end
    want = results_due.pop_front();
    compare_field("status", 32'(want.status), 32'(status_o));
    compare_field("command", 32'(want.command), 32'(command_o));
    compare_field("mode_now", 32'(want.mode), 32'(mode_now_o));
    compare_field("word_one", want.word_one, word_one_o);
    compare_field("word_two", want.word_two, word_two_o);
    compare_field("word_three", want.word_three, word_three_o);
  endfunction

  // Result sink: take beats, honour a long hold-off, otherwise stall at random
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_result();
      if (recv_hold_left > 0) begin
        recv_hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one byte, idling first at random; return once it is taken
  task automatic send_beat(input logic [7:0] b, input logic start);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    frame_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    track_byte(b, start);
    beats_sent++;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fdata,
                            input flaw_e flaw, input fill_e fill, input logic lead_start);
    logic [7:0] frm [16];
    logic [7:0] sum;
    logic [7:0] chk;
    int         k;
    frm[1] = ftype;
    frm[2] = fdata;
    for (k = 3; k < 15; k++) begin
      case (fill)
        FILL_ZERO: frm[k] = 8'h00;
        FILL_ONES: frm[k] = 8'hFF;
        default:   frm[k] = 8'($urandom);
      endcase
    end
    sum = '0;
    chk = '0;
    for (k = 1; k < 15; k++) begin
      sum = sum + frm[k];
      chk = chk ^ frm[k];
    end
    frm[0]  = sum;
    frm[15] = chk;
    if (flaw == FLAW_SUM || flaw == FLAW_BOTH) frm[0] = frm[0] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_XOR || flaw == FLAW_BOTH) frm[15] = frm[15] ^ 8'($urandom_range(1, 255));
    send_beat(frm[0], lead_start);
    for (k = 1; k < 16; k++) send_beat(frm[k], 1'b0);
  endtask

  // Start a frame and leave it unfinished; the next frame start drops it
  task automatic send_partial(input int n);
    int k;
    send_beat(8'($urandom), 1'b1);
    for (k = 1; k < n; k++) send_beat(8'($urandom), 1'b0);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_mode_gating();
    // commands refused in manual, bad data bytes, mode changes, unknown types
    send_frame(TypeVelocity, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeFire, 8'h00, FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeTake, 8'h00, FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeReturn, DataControl, FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypePitch, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeTake, DataControl, FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeVelocity, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypePitch, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeMagazine, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeFire, DataFire, FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeFire, DataControl, FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeReturn, DataFire, FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(8'h00, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(8'hFF, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b1);
  endtask

  task automatic test_check_bytes();
    // a bad check byte must not change the mode
    send_frame(TypeReturn, DataControl, FLAW_SUM, FILL_RANDOM, 1'b1);
    send_frame(TypeReturn, DataControl, FLAW_XOR, FILL_RANDOM, 1'b1);
    send_frame(TypeFire, DataFire, FLAW_BOTH, FILL_RANDOM, 1'b1);
  endtask

  task automatic test_frame_sync();
    // drop a partial frame, then run on without frame start across the wrap
    send_partial(7);
    send_frame(TypeVelocity, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b1);
    send_frame(TypeMagazine, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b0);
    send_partial(15);
    send_frame(TypeFire, DataFire, FLAW_NONE, FILL_RANDOM, 1'b1);
  endtask

  task automatic test_payload_extremes();
    send_frame(TypeVelocity, 8'h00, FLAW_NONE, FILL_ZERO, 1'b1);
    send_frame(TypeVelocity, 8'hFF, FLAW_NONE, FILL_ONES, 1'b1);
  endtask

  task automatic test_backpressure();
    // hold the sink off so the result register fills and stalls the input
    wait_results_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_left = 300;
    repeat (3) send_frame(TypePitch, 8'($urandom), FLAW_NONE, FILL_RANDOM, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_beats);
    int         stop_at;
    int         pick;
    int         k;
    logic [7:0] ftype;
    logic [7:0] fdata;
    flaw_e      flaw;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick  = $urandom_range(0, 99);
      fdata = 8'($urandom);
      flaw  = FLAW_NONE;
      if (pick < 12) begin
        ftype = TypeTake;
        fdata = DataControl;
      end else if (pick < 18) begin
        ftype = TypeReturn;
        fdata = DataControl;
      end else if (pick < 30) begin
        ftype = TypeVelocity;
      end else if (pick < 40) begin
        ftype = TypePitch;
      end else if (pick < 50) begin
        ftype = TypeMagazine;
      end else if (pick < 62) begin
        ftype = TypeFire;
        if ($urandom_range(0, 4) != 0) fdata = DataFire;
      end else if (pick < 70) begin
        ftype = ($urandom_range(0, 1) != 0) ? TypeTake : TypeReturn;
      end else if (pick < 78) begin
        ftype = 8'($urandom);
        flaw  = flaw_e'($urandom_range(1, 3));
      end else begin
        ftype = 8'($urandom);
      end
      if (pick >= 84 && pick < 90) begin
        send_partial($urandom_range(1, 15));
      end else if (pick >= 95) begin
        // stray bytes with random frame start
        for (k = 0; k < $urandom_range(1, 4); k++)
          send_beat(8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        send_frame(ftype, fdata, flaw, FILL_RANDOM,
                   (pick >= 90) ? 1'b0 : ($urandom_range(0, 9) != 0));
      end
    end
    wait_results_drained();
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = 8'h00;
    frame_start_i  = 1'b0;
    out_ready_i    = 1'b0;
    error_count    = 0;
    beats_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_left = 0;
    rx_pos         = PosHead;
    rx_head        = '0;
    rx_sum         = '0;
    rx_xor         = '0;
    kept_mode      = MODE_MANUAL;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_mode_gating();
    test_check_bytes();
    test_frame_sync();
    test_payload_extremes();
    test_backpressure();
    test_random_traffic(0, 0, 130);
    test_random_traffic(69, 0, 130);
    test_random_traffic(0, 69, 130);
    test_random_traffic(25, 25, 130);

    repeat (10) @(posedge clk_i);
    if (results_due.size() != 0) begin
      $error("%0d frame results never arrived", results_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_host_command_frame_decoder_core: done, clean");
    end else begin
      $display("tb_host_command_frame_decoder_core: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_host_command_frame_decoder_core: done, errors");
    $finish;
  end

endmodule
